// ===== sv/crr_pkg.sv =====
// Shared types and constants of the compressor run recorder.
`timescale 1ns / 1ps
package crr_pkg;

	localparam int TEMP_BITS_DEF = 16;
	localparam int SUM_W         = 48;
	localparam int TS_W          = 32;
	localparam int CNT_W         = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [15:0] GAP_LIMIT_RST     = 16'd62;
	localparam logic [15:0] LOCKOUT_DELAY_RST = 16'd480;
	localparam int          HELD_RST          = -1000;

	localparam logic [1:0] MODE_HEAT      = 2'd0;
	localparam logic [1:0] MODE_WATER     = 2'd1;
	localparam logic [1:0] MODE_COMBINED  = 2'd2;
	localparam logic [1:0] MODE_INTERRUPT = 2'd3;

	localparam logic [1:0] REG_WIN_START = 2'd0;
	localparam logic [1:0] REG_WIN_END   = 2'd1;
	localparam logic [1:0] REG_GAP_LIMIT = 2'd2;
	localparam logic [1:0] REG_LOCKOUT   = 2'd3;

	// record entry layout, low bits first
	localparam int E_REC_W  = 2 * TS_W + 1 + TS_W + 2;
	localparam int E_SUM_LO = E_REC_W;
	localparam int E_CNT_LO = E_SUM_LO + SUM_W;
	localparam int E_HELD_LO = E_CNT_LO + CNT_W;

	typedef enum logic [1:0] {
		CMP_OFF,
		CMP_ON,
		CMP_INVALID
	} cmp_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_WAIT
	} back_state_t;

	typedef struct packed {
		logic [TS_W-1:0] window_start;
		logic [TS_W-1:0] window_end;
		logic [15:0]     gap_limit;
		logic [15:0]     lockout_delay;
	} cfg_t;

endpackage

// ===== sv/crr_front.sv =====
// Sample classification, run tracking and record request generation.
`timescale 1ns / 1ps
module crr_front import crr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF,
	parameter int ENTRY_W   = E_HELD_LO + 6 * TEMP_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [TS_W-1:0]             timestamp,
	input  logic                        compressor_on,
	input  logic                        supply_lock,
	input  logic [1:0]                  heat_mode,
	input  logic signed [TEMP_BITS-1:0] outdoor_temp,
	input  logic [6*TEMP_BITS-1:0]      other_temps,
	input  logic                        q_full,
	output logic                        push,
	output logic [ENTRY_W-1:0]          push_data
);

	logic                  seen_q;
	cmp_state_t            cs_q;
	logic                  lock_q;
	logic [TS_W-1:0]       lrt_q;
	logic [TS_W-1:0]       prev_q;
	logic [1:0]            first_q;
	logic [TS_W-1:0]       let_q [2];
	logic [TS_W-1:0]       start_q;
	logic [1:0]            mode_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [6*TEMP_BITS-1:0] held_q;

	logic                  acc, in_win, gap, pv;
	logic [1:0]            first_v;
	cmp_state_t            cs_v;
	logic [TS_W-1:0]       lrt_v, pause;
	logic [1:0]            m_end;
	logic [SUM_W-1:0]      od_ext;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign in_win   = !((cfg.window_start != '0 && timestamp < cfg.window_start) ||
		(cfg.window_end != '0 && timestamp > cfg.window_end));
	assign od_ext   = {{(SUM_W-TEMP_BITS){outdoor_temp[TEMP_BITS-1]}}, outdoor_temp};

	always_comb begin
		gap     = (timestamp - prev_q) > {16'd0, cfg.gap_limit};
		first_v = gap ? 2'b11 : first_q;
		cs_v    = (gap && compressor_on) ? CMP_INVALID : cs_q;
		lrt_v   = (!supply_lock && lock_q) ? timestamp : lrt_q;
		pv      = 1'b0;
		pause   = '0;
		if (mode_q <= MODE_WATER && !first_v[mode_q[0]] &&
			(start_q - lrt_v) > {16'd0, cfg.lockout_delay}) begin
			pv    = 1'b1;
			pause = start_q - let_q[mode_q[0]];
		end
		m_end = supply_lock ? MODE_INTERRUPT : mode_q;
	end

	assign push = acc && in_win && seen_q && !compressor_on && cs_v == CMP_ON;
	assign push_data = {held_q, cnt_q, sum_q, m_end, pause, pv,
		timestamp - start_q, start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			cs_q    <= CMP_OFF;
			lock_q  <= 1'b0;
			lrt_q   <= '0;
			prev_q  <= '0;
			first_q <= 2'b11;
			start_q <= '0;
			mode_q  <= MODE_HEAT;
			sum_q   <= '0;
			cnt_q   <= '0;
			held_q  <= {6{TEMP_BITS'(HELD_RST)}};
		end else if (acc && in_win) begin
			prev_q <= timestamp;
			if (!seen_q) begin
				first_q <= 2'b11;
				cs_q    <= compressor_on ? CMP_INVALID : CMP_OFF;
				lrt_q   <= '0;
				lock_q  <= supply_lock;
				seen_q  <= 1'b1;
			end else begin
				lock_q  <= supply_lock;
				lrt_q   <= lrt_v;
				first_q <= first_v;
				cs_q    <= cs_v;
				if (compressor_on) begin
					unique case (cs_v)
						CMP_OFF: begin
							start_q <= timestamp;
							mode_q  <= heat_mode;
							sum_q   <= od_ext;
							cnt_q   <= CNT_W'(1);
							cs_q    <= CMP_ON;
						end
						CMP_ON: begin
							sum_q  <= sum_q + od_ext;
							if (cnt_q != '1)
								cnt_q <= cnt_q + 1'b1;
							held_q <= other_temps;
							if (mode_q != heat_mode)
								mode_q <= MODE_COMBINED;
						end
						default: mode_q <= heat_mode;
					endcase
				end else begin
					cs_q <= CMP_OFF;
					if (cs_v == CMP_ON) begin
						mode_q <= m_end;
						if (mode_q <= MODE_WATER) begin
							first_q[mode_q[0]] <= supply_lock;
						end else begin
							first_q <= 2'b11;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_win && seen_q && !compressor_on) begin
			if (cs_v == CMP_INVALID && mode_q <= MODE_WATER)
				let_q[mode_q[0]] <= timestamp;
			if (cs_v == CMP_ON) begin
				if (mode_q <= MODE_WATER) begin
					let_q[mode_q[0]] <= timestamp;
				end else begin
					let_q[0] <= timestamp;
					let_q[1] <= timestamp;
				end
			end
		end
	end

endmodule

// ===== sv/crr_queue.sv =====
// Short record queue between front and back.
`timescale 1ns / 1ps
module crr_queue import crr_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full     = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule

// ===== sv/crr_back.sv =====
// Serial mean divider and output register for run records.
`timescale 1ns / 1ps
module crr_back import crr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF,
	parameter int ENTRY_W   = E_HELD_LO + 6 * TEMP_BITS,
	parameter int OUT_W     = E_REC_W + 7 * TEMP_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_payload
);

	back_state_t      st_q, st_d;
	logic [ENTRY_W-1:0] ent_q;
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [5:0]       step_q;
	logic             neg_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	logic [SUM_W-1:0]     sum_in, mag_in;
	logic [CNT_W-1:0]     div_cnt;
	logic [CNT_W:0]       trial;
	logic                 ge;
	logic [TEMP_BITS-1:0] avg;
	logic                 load_out;

	assign sum_in  = q_data[E_SUM_LO +: SUM_W];
	assign mag_in  = sum_in[SUM_W-1] ? (~sum_in + 1'b1) : sum_in;
	assign div_cnt = ent_q[E_CNT_LO +: CNT_W];
	assign trial   = {rem_q, dvd_q[SUM_W-1]};
	assign ge      = trial >= {1'b0, div_cnt};
	assign avg     = neg_q ? (~dvd_q[TEMP_BITS-1:0] + 1'b1) : dvd_q[TEMP_BITS-1:0];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (!q_empty) st_d = BK_DIV;
			BK_DIV:  if (step_q == 6'(SUM_W-1)) st_d = BK_WAIT;
			BK_WAIT: if (!out_valid_q || m_tready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = st_q == BK_IDLE && !q_empty;
		load_out = st_q == BK_WAIT && (!out_valid_q || m_tready);
	end

	assign m_tvalid  = out_valid_q;
	assign m_payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop)
				step_q <= '0;
			else if (st_q == BK_DIV)
				step_q <= step_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_data;
			dvd_q <= mag_in;
			rem_q <= '0;
			neg_q <= sum_in[SUM_W-1];
		end else if (st_q == BK_DIV) begin
			rem_q <= CNT_W'(ge ? (trial - {1'b0, div_cnt}) : trial);
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
		if (load_out)
			out_q <= {ent_q[ENTRY_W-1 -: 6*TEMP_BITS], avg, ent_q[E_REC_W-1:0]};
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_DIV |-> step_q < 6'(SUM_W)) else $error("divider overrun");
	a_rise_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == BK_WAIT) else $error("record without divide");
	a_wait_exit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_WAIT |=> st_q == BK_WAIT || st_q == BK_IDLE) else $error("bad exit");
`endif

endmodule

// ===== sv/compressor_run_recorder.sv =====
// Compressor run recorder top level: register port, front, queue and back.
//
// Slave stream s_* carries heat-pump log samples; each sample accepted at
// s_tvalid & s_tready. Master stream m_* delivers one run record per valid
// run, produced by the off sample that ends the run; other samples yield none.
// The APB port holds the window, gap limit and lockout delay registers; write
// them only while the block is idle.
// A run-ending sample reaches m_tvalid through the record queue and the
// 48-step bit-serial divider computing the mean outdoor temperature.
// Samples are accepted one per cycle while the 2-entry record queue has room;
// the back end pops a new record only after the last one is in the output register.
// Reset clears run tracking, holds -100.0 degrees in the last-temperature
// registers and restores the register defaults. When the receiver stalls,
// the output register holds its record, the queue fills, and s_tready drops.
`timescale 1ns / 1ps
module compressor_run_recorder import crr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// timestamp, compressor_on, supply_lock, heat_mode, outdoor_temp, flow_temp,
	// return_temp, heating_spread, source_in_temp, source_out_temp, source_spread
	input  logic [((TS_W + 4 + 7 * TEMP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// run_start, run_length, pause_valid, pause_length, run_mode, avg_outdoor,
	// last_flow, last_return, last_heating_spread, last_source_in,
	// last_source_out, last_source_spread
	output logic [((E_REC_W + 7 * TEMP_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int OUT_RAW     = E_REC_W + 7 * TEMP_BITS;
	localparam int OUT_BYTES_W = ((OUT_RAW + 7) / 8) * 8;
	localparam int ENTRY_W     = E_HELD_LO + 6 * TEMP_BITS;

	cfg_t                cfg_q;
	logic                wr;
	logic                q_full, q_empty, push, pop;
	logic [ENTRY_W-1:0]  push_data, q_data;
	logic [OUT_RAW-1:0]  payload;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start  <= '0;
			cfg_q.window_end    <= '0;
			cfg_q.gap_limit     <= GAP_LIMIT_RST;
			cfg_q.lockout_delay <= LOCKOUT_DELAY_RST;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_WIN_START: cfg_q.window_start  <= pwdata;
				REG_WIN_END:   cfg_q.window_end    <= pwdata;
				REG_GAP_LIMIT: cfg_q.gap_limit     <= pwdata[15:0];
				REG_LOCKOUT:   cfg_q.lockout_delay <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIN_START: prdata = cfg_q.window_start;
			REG_WIN_END:   prdata = cfg_q.window_end;
			REG_GAP_LIMIT: prdata = {16'd0, cfg_q.gap_limit};
			REG_LOCKOUT:   prdata = {16'd0, cfg_q.lockout_delay};
			default:       prdata = '0;
		endcase
	end

	crr_front #(.TEMP_BITS(TEMP_BITS), .ENTRY_W(ENTRY_W)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.timestamp     (s_tdata[TS_W-1:0]),
		.compressor_on (s_tdata[TS_W]),
		.supply_lock   (s_tdata[TS_W+1]),
		.heat_mode     (s_tdata[TS_W+3:TS_W+2]),
		.outdoor_temp  (s_tdata[TS_W+4 +: TEMP_BITS]),
		.other_temps   (s_tdata[TS_W+4+TEMP_BITS +: 6*TEMP_BITS]),
		.q_full        (q_full),
		.push          (push),
		.push_data     (push_data)
	);

	crr_queue #(.W(ENTRY_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	crr_back #(.TEMP_BITS(TEMP_BITS), .ENTRY_W(ENTRY_W), .OUT_W(OUT_RAW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_payload (payload)
	);

	assign m_tdata = OUT_BYTES_W'(payload);

endmodule
